// File: rtl/core/bmorph_pkg.sv
package bmorph_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W  = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PIX_W  = 8;
    localparam int POS_W  = 10;
    localparam int IDX_W  = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] MAX_WIDTH_C  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_HEIGHT_C = CFG_W'(MAX_HEIGHT);

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    // flag pair per pixel: bit 0 exactly white, bit 1 exactly black
    localparam logic [1:0] FLAG_WHITE = 2'b01;
    localparam logic [1:0] FLAG_BLACK = 2'b10;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic OP_CONTRACT = 1'b0;
    localparam logic OP_EXPAND   = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_MORPH_OP     = 2'd2,
        CFG_EIGHT_NEIGH  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } out_word_t;

endpackage

// File: rtl/core/binary_morphology_3x3.sv
// 3x3 binary erosion / dilation on a raster-order 8-bit pixel stream.
// Input channel (in_valid/in_ready/in_data): a word is either a pixel
// (func = pixel) or a drain tick. Output channel (out_valid/out_ready/
// out_data): result pixel 0 or 255 with its row, column and a frame_last mark.
// Result pixel p leaves when input pixel p+W+1 is taken; the last W+1 results
// of a frame are released one per drain tick after the final pixel. Border
// results are always 255; pixels past a full frame and early drain ticks give
// no result.
// out_valid rises in the cycle after the accepting edge. Throughput: one word
// per clock while the receiver does not stall; the line memory is read one
// address ahead (registered) and written on each accepted pixel, the window
// updates on each accepted pixel and the result register loads on each result.
// When the receiver stalls, the result register holds and in_ready drops
// until that word is taken; in_ready stays high while the register can move.
// Reset: size 640x480, contract mode, 8-neighbour window, frame position zero.
// Line memory is not cleared; stale entries only feed border results.
// Any configuration write restarts the frame.
module binary_morphology_3x3 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bmorph_pkg::in_word_t       in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bmorph_pkg::out_word_t      out_data,
    input  logic                       cfg_wr_en,
    input  logic [bmorph_pkg::IDX_W-1:0] cfg_index,
    input  logic [bmorph_pkg::CFG_W-1:0] cfg_data
);
    import bmorph_pkg::*;

    // configuration
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic             morph_op_reg;
    logic             eight_neighbours_reg;

    // frame position
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic             in_done_reg, in_done_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [17:0]      window_reg, window_next;

    // line memory, entry = {row-2 flags, row-1 flags}
    logic [3:0]       line_mem [MAX_WIDTH];
    logic [3:0]       line_rd_reg;
    logic [3:0]       line_wdata;

    logic             out_valid_reg;
    out_word_t        out_data_reg;

    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic [CFG_W-1:0] width_m1;
    logic [CFG_W-1:0] height_m1;

    logic             in_fire;
    logic             pix_fire;
    logic             drain_emit;
    logic             pix_emit;
    logic             emit;
    logic             primed;
    logic             interior;
    logic             is_last;
    logic             col_end;
    logic             row_end;
    logic             out_col_end;
    logic             out_row_end;
    logic             restart;
    logic             cfg_hit;
    logic [1:0]       cur_flags;
    logic [5:0]       new_col;
    logic [1:0]       sel;
    logic [1:0]       acc;
    logic [PIX_W-1:0] value;
    out_word_t        result;

    // effective last column / row index (0 acts as 1, saturate at max)
    assign width_m1  = image_width_reg - CFG_W'(1);
    assign height_m1 = image_height_reg - CFG_W'(1);

    always_comb
    begin
        if (image_width_reg == '0)
            w_last = '0;
        else if (image_width_reg > MAX_WIDTH_C)
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = width_m1[COL_W-1:0];

        if (image_height_reg == '0)
            h_last = '0;
        else if (image_height_reg > MAX_HEIGHT_C)
            h_last = ROW_W'(MAX_HEIGHT - 1);
        else
            h_last = height_m1[ROW_W-1:0];
    end

    assign in_ready   = !out_valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign pix_fire   = in_fire && (in_data.func == FUNC_PIXEL) && !in_done_reg;
    assign drain_emit = in_fire && (in_data.func == FUNC_DRAIN) && in_done_reg;

    assign col_end  = (in_col_reg == w_last);
    assign row_end  = (in_row_reg == h_last);
    assign is_last  = col_end && row_end;
    // pixel index >= W+1
    assign primed   = (in_row_reg >= ROW_W'(2)) ||
                      ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign interior = (in_row_reg >= ROW_W'(2)) && (in_col_reg >= COL_W'(2));
    assign pix_emit = pix_fire && primed;
    assign emit     = pix_emit || drain_emit;

    assign out_col_end = (out_col_reg == w_last);
    assign out_row_end = (out_row_reg == h_last);

    assign cfg_hit = cfg_wr_en && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                   (cfg_index == CFG_IMAGE_HEIGHT) ||
                                   (cfg_index == CFG_MORPH_OP) ||
                                   (cfg_index == CFG_EIGHT_NEIGH));
    assign restart = cfg_hit || (emit && out_col_end && out_row_end);

    // window column: current pixel, row above, two rows above
    always_comb
    begin
        cur_flags = {in_data.pixel_in == PIX_BLACK, in_data.pixel_in == PIX_WHITE};
        new_col     = {line_rd_reg, cur_flags};
        window_next = {window_reg[11:0], new_col};
        line_wdata  = {line_rd_reg[1:0], cur_flags};
    end

    always_comb
    begin
        sel = (morph_op_reg == OP_EXPAND) ? FLAG_BLACK : FLAG_WHITE;
        acc = sel & window_next[3:2] & window_next[7:6] & window_next[9:8]
                  & window_next[11:10] & window_next[15:14];
        if (eight_neighbours_reg)
            acc = acc & window_next[1:0] & window_next[5:4]
                      & window_next[13:12] & window_next[17:16];

        if (pix_emit && interior)
        begin
            if (morph_op_reg == OP_EXPAND)
                value = (acc != '0) ? PIX_BLACK : PIX_WHITE;
            else
                value = (acc != '0) ? PIX_WHITE : PIX_BLACK;
        end
        else
            value = PIX_WHITE;

        result.pixel_out  = value;
        result.out_row    = POS_W'(out_row_reg);
        result.out_col    = POS_W'(out_col_reg);
        result.frame_last = out_col_end && out_row_end;
    end

    // position counters
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (pix_fire)
        begin
            if (col_end)
            begin
                in_col_next = '0;
                in_row_next = row_end ? '0 : in_row_reg + ROW_W'(1);
            end
            else
                in_col_next = in_col_reg + COL_W'(1);
            in_done_next = is_last;
        end

        if (emit)
        begin
            if (out_col_end)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
            end
            else
                out_col_next = out_col_reg + COL_W'(1);
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg      <= WIDTH_RESET;
            image_height_reg     <= HEIGHT_RESET;
            morph_op_reg         <= OP_CONTRACT;
            eight_neighbours_reg <= 1'b1;
            in_col_reg           <= '0;
            in_row_reg           <= '0;
            in_done_reg          <= 1'b0;
            out_col_reg          <= '0;
            out_row_reg          <= '0;
            window_reg           <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  image_width_reg      <= cfg_data;
                    CFG_IMAGE_HEIGHT: image_height_reg     <= cfg_data;
                    CFG_MORPH_OP:     morph_op_reg         <= cfg_data[0];
                    CFG_EIGHT_NEIGH:  eight_neighbours_reg <= cfg_data[0];
                    default:          ;
                endcase
            end

            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;

            if (restart)
                window_reg <= '0;
            else if (pix_fire)
                window_reg <= window_next;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= result;
    end

    // line memory: read one column ahead so the data is ready when the word
    // arrives; forward the write when both hit the same column
    always_ff @(posedge clk)
    begin
        if (pix_fire)
            line_mem[in_col_reg] <= line_wdata;

        if (pix_fire && (in_col_reg == in_col_next))
            line_rd_reg <= line_wdata;
        else
            line_rd_reg <= line_mem[in_col_next];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result word lost");

    a_frame_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_last) |->
            ((out_data_reg.out_row == POS_W'(h_last)) &&
             (out_data_reg.out_col == POS_W'(w_last))))
        else $error("frame_last away from final pixel");

    a_border_white: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.out_row == '0)) |->
            (out_data_reg.pixel_out == PIX_WHITE))
        else $error("top border not white");

    a_done_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        in_done_reg |-> ((in_row_reg == '0) && (in_col_reg == '0)))
        else $error("input position not wrapped at frame end");
`endif

endmodule
